@@ src/hnm_pkg.sv @@
`default_nettype none
package hnm_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int RowW       = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 2;

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(1024);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(1024);

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int SumW  = 18;
  localparam int AW    = 15;
  localparam int A2W   = 30;
  localparam int QW    = 7;
  localparam int Q2sW  = 34;
  localparam int QsW   = 25;
  localparam int Steps = 7;

  localparam logic [7:0]      Bias    = 8'd127;
  localparam logic [SumW-1:0] ZTermSq = SumW'(2601);
  localparam logic [A2W-1:0]  ZA2     = A2W'(127 * 51 * 127 * 51);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ALPHA  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] height_sample;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic [7:0] normal_z;
    logic [7:0] alpha_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic        drain;
    logic        first_col;
    logic        last_col;
    logic        fend;
    logic [7:0]  down;
    logic [15:0] cur;
    logic [7:0]  right;
  } job_t;

  typedef struct packed {
    logic [QW-1:0]   q;
    logic [Q2sW-1:0] q2s;
    logic [QsW-1:0]  qs;
    logic [A2W-1:0]  a2;
    logic            neg;
  } comp_t;

  function automatic comp_t search_step(comp_t c, logic [SumW-1:0] s, int k);
    comp_t           r;
    logic [Q2sW-1:0] cand;
    r    = c;
    cand = c.q2s + (Q2sW'(c.qs) << (k + 1)) + (Q2sW'(s) << (2 * k));
    if (cand <= Q2sW'(c.a2)) begin
      r.q   = c.q | (QW'(1) << k);
      r.q2s = cand;
      r.qs  = c.qs + (QsW'(s) << k);
    end
    return r;
  endfunction

  function automatic logic [7:0] finish_comp(comp_t c);
    logic [7:0] qa;
    qa = {1'b0, c.q};
    if (c.neg && (c.q2s != Q2sW'(c.a2))) begin
      qa = qa + 8'd1;
    end
    return c.neg ? (Bias - qa) : (Bias + qa);
  endfunction

endpackage
`default_nettype wire

@@ src/hnm_ifs.sv @@
`default_nettype none
interface hnm_in_if;
  logic               valid;
  logic               ready;
  hnm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hnm_out_if;
  logic               valid;
  logic               ready;
  hnm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/hnm_ram.sv @@
`default_nettype none
module hnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/hnm_front.sv @@
`default_nettype none
module hnm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  hnm_in_if.sink                            pix_in,
  input  wire logic                         cfg_we,
  input  wire logic [hnm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hnm_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic [hnm_pkg::QCntW-1:0]    q_count,
  output logic                              job_valid,
  output hnm_pkg::job_t                     job,
  output logic                              has_alpha
);

  logic [hnm_pkg::WidthRegW-1:0]  width_reg;
  logic [hnm_pkg::HeightRegW-1:0] height_reg;
  logic                           alpha_reg;
  logic [hnm_pkg::ColW-1:0]       col;
  logic [hnm_pkg::RowW-1:0]       row;
  logic                           draining;

  logic       st_drain, st_first, st_last;
  logic [7:0] st_hs;

  logic [hnm_pkg::WidthRegW-1:0]  eff_w;
  logic [hnm_pkg::HeightRegW-1:0] eff_h;
  logic [hnm_pkg::WidthRegW-1:0]  x_p1;
  logic [hnm_pkg::RowW:0]         row_p1;
  logic                           last_col, row_done;
  logic [hnm_pkg::ColW-1:0]       right_addr;
  logic                           accept, is_drain, pix_ok, drn_ok;
  logic [hnm_pkg::QCntW:0]        fill;
  logic [15:0]                    prev_a_rd, prev_b_rd;
  logic [7:0]                     first_rd;
  logic [15:0]                    prev_wdata;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = hnm_pkg::WidthRegW'(1);
    end else if (width_reg > hnm_pkg::WidthRegW'(hnm_pkg::MaxWidth)) begin
      eff_w = hnm_pkg::WidthRegW'(hnm_pkg::MaxWidth);
    end else begin
      eff_w = width_reg;
    end
    if (height_reg == '0) begin
      eff_h = hnm_pkg::HeightRegW'(1);
    end else if (height_reg > hnm_pkg::HeightRegW'(hnm_pkg::MaxHeight)) begin
      eff_h = hnm_pkg::HeightRegW'(hnm_pkg::MaxHeight);
    end else begin
      eff_h = height_reg;
    end
  end

  assign x_p1       = {1'b0, col} + hnm_pkg::WidthRegW'(1);
  assign last_col   = (x_p1 == eff_w);
  assign right_addr = last_col ? '0 : x_p1[hnm_pkg::ColW-1:0];
  assign row_p1     = {1'b0, row} + (hnm_pkg::RowW + 1)'(1);
  assign row_done   = (row_p1 >= {1'b0, eff_h});

  assign fill         = {1'b0, q_count} + (hnm_pkg::QCntW + 1)'(job_valid);
  assign pix_in.ready = (fill < (hnm_pkg::QCntW + 1)'(hnm_pkg::QueueDepth));
  assign accept       = pix_in.valid && pix_in.ready;
  assign is_drain     = (pix_in.data.req_type == hnm_pkg::REQ_DRAIN);
  assign pix_ok       = accept && !is_drain && !draining;
  assign drn_ok       = accept && is_drain && draining;
  assign prev_wdata   = {pix_in.data.height_sample, pix_in.data.alpha_in};

  // two copies of the row store give two reads a cycle
  hnm_ram #(.Width(16), .Depth(hnm_pkg::MaxWidth)) u_prev_a (
    .clk(clk), .we(pix_ok), .waddr(col), .wdata(prev_wdata),
    .raddr(col), .rdata(prev_a_rd)
  );

  hnm_ram #(.Width(16), .Depth(hnm_pkg::MaxWidth)) u_prev_b (
    .clk(clk), .we(pix_ok), .waddr(col), .wdata(prev_wdata),
    .raddr(right_addr), .rdata(prev_b_rd)
  );

  hnm_ram #(.Width(8), .Depth(hnm_pkg::MaxWidth)) u_first (
    .clk(clk), .we(pix_ok && (row == '0)), .waddr(col),
    .wdata(pix_in.data.height_sample), .raddr(col), .rdata(first_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= hnm_pkg::WidthReset;
      height_reg <= hnm_pkg::HeightReset;
      alpha_reg  <= 1'b0;
      col        <= '0;
      row        <= '0;
      draining   <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      job_valid <= (pix_ok && (row != '0)) || drn_ok;
      if (cfg_we) begin
        unique case (cfg_index)
          hnm_pkg::CFG_WIDTH: begin
            width_reg <= cfg_data[hnm_pkg::WidthRegW-1:0];
            col <= '0; row <= '0; draining <= 1'b0;
          end
          hnm_pkg::CFG_HEIGHT: begin
            height_reg <= cfg_data[hnm_pkg::HeightRegW-1:0];
            col <= '0; row <= '0; draining <= 1'b0;
          end
          hnm_pkg::CFG_ALPHA: begin
            alpha_reg <= cfg_data[0];
            col <= '0; row <= '0; draining <= 1'b0;
          end
          default: begin
          end
        endcase
      end else if (pix_ok) begin
        if (last_col) begin
          col <= '0;
          if (row_done) begin
            row      <= eff_h;
            draining <= 1'b1;
          end else begin
            row <= row_p1[hnm_pkg::RowW-1:0];
          end
        end else begin
          col <= x_p1[hnm_pkg::ColW-1:0];
        end
      end else if (drn_ok) begin
        if (last_col) begin
          col <= '0; row <= '0; draining <= 1'b0;
        end else begin
          col <= x_p1[hnm_pkg::ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    st_drain <= is_drain;
    st_first <= (col == '0);
    st_last  <= last_col;
    st_hs    <= pix_in.data.height_sample;
  end

  always_comb begin
    job.drain     = st_drain;
    job.first_col = st_first;
    job.last_col  = st_last;
    job.fend      = st_drain && st_last;
    job.down      = st_drain ? first_rd : st_hs;
    job.cur       = prev_a_rd;
    job.right     = prev_b_rd[15:8];
  end

  assign has_alpha = alpha_reg;

endmodule
`default_nettype wire

@@ src/hnm_queue.sv @@
`default_nettype none
module hnm_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire hnm_pkg::job_t             din,
  input  wire logic                      pop,
  output hnm_pkg::job_t                  dout,
  output logic                           not_empty,
  output logic [hnm_pkg::QCntW-1:0]      count
);

  hnm_pkg::job_t              slots [hnm_pkg::QueueDepth];
  logic [hnm_pkg::QPtrW-1:0]  wr_ptr, rd_ptr;

  assign dout      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hnm_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hnm_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + hnm_pkg::QCntW'(1);
      end else if (pop && !push) begin
        count <= count - hnm_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

@@ src/hnm_back.sv @@
`default_nettype none
module hnm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire hnm_pkg::job_t q_data,
  output logic               pop,
  input  wire logic          has_alpha,
  hnm_out_if.source          nrm_out
);

  logic       en;
  logic [7:0] saved_left;

  logic [7:0]       hc, right;
  logic signed [8:0] dx, dy;
  logic [7:0]       mag_x, mag_y;

  logic             v0, neg_x0, neg_y0, fend0;
  logic [7:0]       mx0, my0, alpha0;
  logic [hnm_pkg::AW-1:0] ax0, ay0;

  logic                    sv     [hnm_pkg::Steps+1];
  logic [hnm_pkg::SumW-1:0] s_st  [hnm_pkg::Steps+1];
  logic [7:0]              al_st  [hnm_pkg::Steps+1];
  logic                    fe_st  [hnm_pkg::Steps+1];
  hnm_pkg::comp_t          cp     [hnm_pkg::Steps+1][3];

  logic               out_valid;
  hnm_pkg::out_item_t out_data;

  assign en  = !out_valid || nrm_out.ready;
  assign pop = q_valid && en;

  always_comb begin
    hc = q_data.cur[15:8];
    if (q_data.drain || !q_data.last_col) begin
      right = q_data.right;
    end else begin
      right = q_data.first_col ? hc : saved_left;
    end
    dx    = $signed({1'b0, hc}) - $signed({1'b0, right});
    dy    = $signed({1'b0, q_data.down}) - $signed({1'b0, hc});
    mag_x = dx[8] ? 8'(-dx) : dx[7:0];
    mag_y = dy[8] ? 8'(-dy) : dy[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_left <= '0;
      v0         <= 1'b0;
    end else begin
      if (pop && !q_data.drain && q_data.first_col) begin
        saved_left <= hc;
      end
      if (en) begin
        v0 <= q_valid;
      end
    end
  end

  // operand prep
  always_ff @(posedge clk) begin
    if (en) begin
      neg_x0 <= dx[8];
      neg_y0 <= dy[8];
      mx0    <= mag_x;
      my0    <= mag_y;
      ax0    <= (hnm_pkg::AW'(mag_x) << 7) - hnm_pkg::AW'(mag_x);
      ay0    <= (hnm_pkg::AW'(mag_y) << 7) - hnm_pkg::AW'(mag_y);
      alpha0 <= has_alpha ? q_data.cur[7:0] : 8'hff;
      fend0  <= q_data.fend;
    end
  end

  // squares and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_st[0]  <= hnm_pkg::SumW'(mx0 * mx0) + hnm_pkg::SumW'(my0 * my0)
                  + hnm_pkg::ZTermSq;
      al_st[0] <= alpha0;
      fe_st[0] <= fend0;
      cp[0][0] <= '{q: '0, q2s: '0, qs: '0,
                    a2: hnm_pkg::A2W'(ax0 * ax0), neg: neg_x0};
      cp[0][1] <= '{q: '0, q2s: '0, qs: '0,
                    a2: hnm_pkg::A2W'(ay0 * ay0), neg: neg_y0};
      cp[0][2] <= '{q: '0, q2s: '0, qs: '0, a2: hnm_pkg::ZA2, neg: 1'b0};
    end
  end

  // one quotient bit a stage, most significant first
  for (genvar g = 0; g < hnm_pkg::Steps; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g+1] <= 1'b0;
      end else if (en) begin
        sv[g+1] <= sv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_st[g+1]  <= s_st[g];
        al_st[g+1] <= al_st[g];
        fe_st[g+1] <= fe_st[g];
        for (int c = 0; c < 3; c++) begin
          cp[g+1][c] <= hnm_pkg::search_step(cp[g][c], s_st[g],
                                             hnm_pkg::Steps - 1 - g);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[hnm_pkg::Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.normal_x  <= hnm_pkg::finish_comp(cp[hnm_pkg::Steps][0]);
      out_data.normal_y  <= hnm_pkg::finish_comp(cp[hnm_pkg::Steps][1]);
      out_data.normal_z  <= hnm_pkg::finish_comp(cp[hnm_pkg::Steps][2]);
      out_data.alpha_out <= al_st[hnm_pkg::Steps];
      out_data.frame_end <= fe_st[hnm_pkg::Steps];
    end
  end

  assign nrm_out.valid = out_valid;
  assign nrm_out.data  = out_data;

endmodule
`default_nettype wire

@@ src/height_to_normal_map.sv @@
// throughput: one beat per cycle, set by the row store reads and the bit-per-stage
// quotient pipeline; input stalls only when queued and pending jobs fill the 4-entry queue
// reset: synchronous, clears counters and pipeline valids and restores the config
// registers to their defaults; the row stores are not cleared
`default_nettype none
module height_to_normal_map (
  input  wire logic                         clk,
  input  wire logic                         rst,
  hnm_in_if.sink                            pix_in,
  hnm_out_if.source                         nrm_out,
  input  wire logic                         cfg_we,
  input  wire logic [hnm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hnm_pkg::CfgDataW-1:0] cfg_data
);

  logic                        job_valid;
  hnm_pkg::job_t               job;
  logic                        has_alpha;
  logic                        q_valid;
  hnm_pkg::job_t               q_data;
  logic                        pop;
  logic [hnm_pkg::QCntW-1:0]   q_count;

  hnm_front u_front (
    .clk(clk), .rst(rst), .pix_in(pix_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_count(q_count), .job_valid(job_valid), .job(job), .has_alpha(has_alpha)
  );

  hnm_queue u_queue (
    .clk(clk), .rst(rst), .push(job_valid), .din(job), .pop(pop),
    .dout(q_data), .not_empty(q_valid), .count(q_count)
  );

  hnm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .has_alpha(has_alpha), .nrm_out(nrm_out)
  );

endmodule
`default_nettype wire

@@ tb/height_to_normal_map_tb.sv @@
`default_nettype none
module height_to_normal_map_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [hnm_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [hnm_pkg::CfgDataW-1:0] cfg_data = '0;
  int errors = 0;

  hnm_in_if pix_in ();
  hnm_out_if nrm_out ();

  height_to_normal_map u_top (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .nrm_out(nrm_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned img_w, img_h;
  bit alpha_on;
  logic [15:0] prev_row [hnm_pkg::MaxWidth];
  logic [7:0] first_row [hnm_pkg::MaxWidth];
  logic [7:0] left_h;
  int unsigned col, row;
  bit draining;
  hnm_pkg::out_item_t normals_due [$];

  function automatic int unsigned eff_w();
    if (img_w < 1) return 1;
    if (img_w > hnm_pkg::MaxWidth) return hnm_pkg::MaxWidth;
    return img_w;
  endfunction

  function automatic int unsigned eff_h();
    if (img_h < 1) return 1;
    if (img_h > hnm_pkg::MaxHeight) return hnm_pkg::MaxHeight;
    return img_h;
  endfunction

  function automatic logic [7:0] biased_comp(int v, longint unsigned s);
    longint unsigned mag, a2, q, t;
    mag = (v < 0) ? -v : v;
    a2 = (127 * mag) * (127 * mag);
    q = 0;
    for (int b = 64; b != 0; b = b >> 1) begin
      t = q + b;
      if (t * t * s <= a2) q = t;
    end
    if (v >= 0) return 8'(127 + q);
    if (q * q * s != a2) q++;
    return 8'(127 - q);
  endfunction

  function automatic hnm_pkg::out_item_t normal_of(int hc, int rgt, int dn, logic [7:0] al,
                                                   bit fe);
    hnm_pkg::out_item_t o;
    int dx, dy;
    longint unsigned s;
    dx = hc - rgt;
    dy = dn - hc;
    s = dx * dx + dy * dy + 2601;
    o.normal_x = biased_comp(dx, s);
    o.normal_y = biased_comp(dy, s);
    o.normal_z = biased_comp(51, s);
    o.alpha_out = alpha_on ? al : 8'hff;
    o.frame_end = fe;
    return o;
  endfunction

  function automatic void restart_frame();
    left_h = 0; col = 0; row = 0; draining = 0;
  endfunction

  function automatic void predict_normal(hnm_pkg::in_item_t it);
    int unsigned w, h, x, rgt;
    logic [15:0] old;
    bit last;
    w = eff_w(); h = eff_h(); x = col;
    if (x >= w) x = 0;
    if (it.req_type == hnm_pkg::REQ_PIXEL) begin
      if (draining) return;
      old = prev_row[x];
      if (x == 0) left_h = old[15:8];
      if (row == 0) begin
        first_row[x] = it.height_sample;
      end else begin
        rgt = (x + 1 < w) ? prev_row[x + 1][15:8] : left_h;
        normals_due.push_back(normal_of(old[15:8], rgt, it.height_sample, old[7:0], 0));
      end
      prev_row[x] = {it.height_sample, it.alpha_in};
      x++;
      if (x >= w) begin
        x = 0;
        row++;
        if (row >= h) begin
          row = h;
          draining = 1;
        end
      end
      col = x;
    end else begin
      if (!draining) return;
      rgt = (x + 1 < w) ? prev_row[x + 1][15:8] : prev_row[0][15:8];
      last = (x + 1 >= w);
      normals_due.push_back(normal_of(prev_row[x][15:8], rgt, first_row[x],
                                      prev_row[x][7:0], last));
      if (last) restart_frame();
      else col = x + 1;
    end
  endfunction

  // receiver stall pattern and checker
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      nrm_out.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: nrm_out.ready <= 1'b1;
        1: nrm_out.ready <= ($urandom_range(3) != 0);
        default: nrm_out.ready <= ($urandom_range(7) < 2);
      endcase
      if (nrm_out.valid && nrm_out.ready) begin
        if (normals_due.size() == 0) begin
          $error("unexpected beat %p", nrm_out.data);
          errors++;
        end else begin
          hnm_pkg::out_item_t e;
          e = normals_due.pop_front();
          if (e.normal_x !== nrm_out.data.normal_x) begin
            $error("normal_x exp %0d got %0d", e.normal_x, nrm_out.data.normal_x); errors++;
          end
          if (e.normal_y !== nrm_out.data.normal_y) begin
            $error("normal_y exp %0d got %0d", e.normal_y, nrm_out.data.normal_y); errors++;
          end
          if (e.normal_z !== nrm_out.data.normal_z) begin
            $error("normal_z exp %0d got %0d", e.normal_z, nrm_out.data.normal_z); errors++;
          end
          if (e.alpha_out !== nrm_out.data.alpha_out) begin
            $error("alpha_out exp %0d got %0d", e.alpha_out, nrm_out.data.alpha_out); errors++;
          end
          if (e.frame_end !== nrm_out.data.frame_end) begin
            $error("frame_end exp %0d got %0d", e.frame_end, nrm_out.data.frame_end); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) stall_mode <= ($urandom_range(63) == 0) ? $urandom_range(2) : stall_mode;
  end

  int unsigned burst_left = 0;

  task automatic send_beat(logic rq, logic [7:0] hs, logic [7:0] al);
    hnm_pkg::in_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(1) == 1) begin
        pix_in.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    it.req_type = rq; it.height_sample = hs; it.alpha_in = al;
    pix_in.valid <= 1'b1;
    pix_in.data <= it;
    do @(posedge clk); while (!pix_in.ready);
    predict_normal(it);
  endtask

  task automatic drain_and_idle();
    int unsigned guard = 0;
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (normals_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(hnm_pkg::cfg_index_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= hnm_pkg::CfgDataW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hnm_pkg::CFG_WIDTH) img_w = val & 'h7ff;
    else if (idx == hnm_pkg::CFG_HEIGHT) img_h = val & 'h1fff;
    else alpha_on = val[0];
    restart_frame();
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, bit a);
    write_reg(hnm_pkg::CFG_WIDTH, w);
    write_reg(hnm_pkg::CFG_HEIGHT, h);
    write_reg(hnm_pkg::CFG_ALPHA, a);
  endtask

  // one full frame; rows written before being read, so every store entry used is known
  task automatic run_frame(bit extremes);
    int unsigned n;
    n = eff_w() * eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      if (extremes) begin
        send_beat(hnm_pkg::REQ_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'hff : 8'h00);
      end else begin
        send_beat(hnm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(15) == 0) send_beat(hnm_pkg::REQ_DRAIN, 8'($urandom), 8'($urandom));
    end
    for (int unsigned i = 0; i < eff_w(); i++) begin
      send_beat(hnm_pkg::REQ_DRAIN, 8'($urandom), 8'($urandom));
      if ($urandom_range(15) == 0) send_beat(hnm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    set_geometry(3, 3, 1);
    run_frame(1);
    drain_and_idle();
    set_geometry(1, 1, 0);
    run_frame(1);
    run_frame(0);
    drain_and_idle();
    set_geometry(4, 1, 1);
    run_frame(0);
    drain_and_idle();
    set_geometry(1, 4, 1);
    run_frame(0);
    drain_and_idle();
  endtask

  task automatic test_partial_frame();
    set_geometry(5, 4, 1);
    repeat (13) send_beat(hnm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom));
    drain_and_idle();
    set_geometry(5, 3, 0);
    run_frame(0);
    drain_and_idle();
  endtask

  task automatic test_register_extremes();
    // out-of-range and largest values, all clamped
    set_geometry(0, 0, 1);
    run_frame(0);
    drain_and_idle();
    set_geometry(2047, 1, 0);
    repeat (40) send_beat(hnm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom));
    drain_and_idle();
    set_geometry(2, 8191, 1);
    repeat (40) send_beat(hnm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom));
    drain_and_idle();
  endtask

  task automatic test_random_frames();
    int unsigned sent = 0;
    while (sent < 500) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1));
      sent += eff_w() * (eff_h() + 1);
      run_frame(0);
      drain_and_idle();
    end
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    img_w = 1024; img_h = 1024; alpha_on = 0;
    restart_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_partial_frame();
    test_register_extremes();
    test_random_frames();
    if (errors == 0 && normals_due.size() == 0) $display("height_to_normal_map_tb: clean");
    else $display("height_to_normal_map_tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("height_to_normal_map_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
src/hnm_pkg.sv
src/hnm_ifs.sv
src/hnm_ram.sv
src/hnm_front.sv
src/hnm_queue.sv
src/hnm_back.sv
src/height_to_normal_map.sv
tb/height_to_normal_map_tb.sv
